/* hw/rtl/arc_pkg.sv */
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the adaptive Rice encoder.
// ----------------------------------------------------------------------------
package arc_pkg;

    // Fixed field widths.
    localparam int unsigned FUNC_W    = 1;
    localparam int unsigned EIDX_W    = 4;
    localparam int unsigned EVAL_W    = 16;
    localparam int unsigned SYM_W     = 9;
    localparam int unsigned S_W       = 8;
    localparam int unsigned WORD_W    = 41;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned K_W       = 4;
    localparam int unsigned COUNT_W   = EVAL_W + 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 56;

    // Model constants.
    localparam int unsigned ALPHABET_SIZE_DEF = 256;
    localparam int unsigned TABLE_DEPTH       = 10;
    localparam int unsigned K_LIMIT           = 7;
    localparam int unsigned K_MIN             = 3;
    localparam int unsigned HALVE_BY          = 2;
    localparam int unsigned NUM_COND          = K_LIMIT + 1;

    // Item kinds carried in tuser.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COND,
        ST_KSEL,
        ST_BUILD,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic capture_en;
        logic cond_en;
        logic k_en;
        logic build_en;
    } cmd_t;

endpackage

/* hw/rtl/adaptive_rice_encoder.sv */
// ----------------------------------------------------------------------------
// adaptive_rice_encoder
// Rice encoder with k chosen from a ten-entry cumulative count table.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one count entry and leaves the controller idle,
// so loads can stream at one per cycle. An encode beat (tuser 1) runs through
// the controller's sequence: a state to test the eight halving conditions,
// then one to pick k, then one to build the code word, then the result beat is
// held in the output register until taken; no input is taken while an encode
// is in flight.
module adaptive_rice_encoder
#(
    parameter int unsigned ALPHABET_SIZE = arc_pkg::ALPHABET_SIZE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index [3:0], entry_value [19:4], symbol_index [28:20], zero pad
    input  logic [arc_pkg::IN_DATA_W-1:0]    s_tdata,
    // func [0]
    input  logic [arc_pkg::FUNC_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // code_word [40:0], code_length [46:41], rice_k [50:47], zero pad
    output logic [arc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int unsigned EVAL_LSB = arc_pkg::EIDX_W;
    localparam int unsigned SYM_LSB  = EVAL_LSB + arc_pkg::EVAL_W;
    localparam int unsigned USED_IN  = SYM_LSB + arc_pkg::SYM_W;
    localparam int unsigned USED_OUT = arc_pkg::WORD_W + arc_pkg::LEN_W + arc_pkg::K_W;

    arc_pkg::cmd_t                cmd;
    logic [arc_pkg::WORD_W-1:0]   code_word;
    logic [arc_pkg::LEN_W-1:0]    code_length;
    logic [arc_pkg::K_W-1:0]      rice_k;

    arc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    arc_datapath
    #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .entry_index  (s_tdata[arc_pkg::EIDX_W-1:0]),
        .entry_value  (s_tdata[SYM_LSB-1:EVAL_LSB]),
        .symbol_index (s_tdata[USED_IN-1:SYM_LSB]),
        .code_word    (code_word),
        .code_length  (code_length),
        .rice_k       (rice_k)
    );

    assign m_tdata = {{(arc_pkg::OUT_DATA_W-USED_OUT){1'b0}}, rice_k, code_length, code_word};

    // Input and output never handshake in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while a result beat is pending");

    // An accepted encode beat raises m_tvalid once the COND, KSEL and BUILD states have passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == arc_pkg::FUNC_ENCODE)) |-> ##4 m_tvalid)
        else $error("encode beat did not produce a result in time");

    // A load beat leaves the block ready for the next beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[0] == arc_pkg::FUNC_LOAD)) |=> (s_tready && !m_tvalid))
        else $error("load beat started an encode");

    // A result carries k in range and a length covering the remainder and stop bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((rice_k >= arc_pkg::K_W'(arc_pkg::K_MIN))
                   && (rice_k <= arc_pkg::K_W'(arc_pkg::NUM_COND))
                   && (code_length > arc_pkg::LEN_W'(rice_k))))
        else $error("result k or length out of range");

endmodule

/* hw/rtl/arc_ctrl.sv */
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer for the adaptive Rice encoder: accepts beats, steps the datapath
// through the k search and code build, and holds the result beat.
// ----------------------------------------------------------------------------
module arc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_func,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output arc_pkg::cmd_t cmd
);

    arc_pkg::state_t state_reg;
    arc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arc_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_func == arc_pkg::FUNC_ENCODE))
                begin
                    state_next = arc_pkg::ST_COND;
                end
            end
            arc_pkg::ST_COND:  state_next = arc_pkg::ST_KSEL;
            arc_pkg::ST_KSEL:  state_next = arc_pkg::ST_BUILD;
            arc_pkg::ST_BUILD: state_next = arc_pkg::ST_OUT;
            arc_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = arc_pkg::ST_IDLE;
                end
            end
            default: state_next = arc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            arc_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load_en    = s_tvalid && (s_func == arc_pkg::FUNC_LOAD);
                cmd.capture_en = s_tvalid && (s_func == arc_pkg::FUNC_ENCODE);
            end
            arc_pkg::ST_COND:  cmd.cond_en  = 1'b1;
            arc_pkg::ST_KSEL:  cmd.k_en     = 1'b1;
            arc_pkg::ST_BUILD: cmd.build_en = 1'b1;
            arc_pkg::ST_OUT:   m_tvalid     = 1'b1;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/arc_datapath.sv */
// ----------------------------------------------------------------------------
// arc_datapath
// Count table, k search and Rice code word construction.
// ----------------------------------------------------------------------------
module arc_datapath
#(
    parameter int unsigned ALPHABET_SIZE = arc_pkg::ALPHABET_SIZE_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  arc_pkg::cmd_t                cmd,
    input  logic [arc_pkg::EIDX_W-1:0]   entry_index,
    input  logic [arc_pkg::EVAL_W-1:0]   entry_value,
    input  logic [arc_pkg::SYM_W-1:0]    symbol_index,
    output logic [arc_pkg::WORD_W-1:0]   code_word,
    output logic [arc_pkg::LEN_W-1:0]    code_length,
    output logic [arc_pkg::K_W-1:0]      rice_k
);

    logic [arc_pkg::EVAL_W-1:0]  table_reg [arc_pkg::TABLE_DEPTH];
    logic [arc_pkg::S_W-1:0]     s_reg;
    logic [arc_pkg::NUM_COND-1:0] cond_reg;
    logic [arc_pkg::NUM_COND-1:0] cond_next;
    logic [arc_pkg::K_W-1:0]     k_reg;
    logic [arc_pkg::K_W-1:0]     k_next;
    logic [arc_pkg::WORD_W-1:0]  word_reg;
    logic [arc_pkg::WORD_W-1:0]  word_next;
    logic [arc_pkg::LEN_W-1:0]   len_reg;
    logic [arc_pkg::LEN_W-1:0]   len_next;
    logic [arc_pkg::SYM_W-1:0]   sym_sat;
    logic signed [arc_pkg::COUNT_W-1:0] p [arc_pkg::NUM_COND+1];

    // The table is state with a defined reset, so it is cleared with control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < arc_pkg::TABLE_DEPTH; j++)
            begin
                table_reg[j] <= '0;
            end
        end
        else if (cmd.load_en && (entry_index < arc_pkg::EIDX_W'(arc_pkg::TABLE_DEPTH)))
        begin
            table_reg[entry_index] <= entry_value;
        end
    end

    // Rank zero and ranks past the alphabet saturate.
    always_comb
    begin
        sym_sat = symbol_index;
        if (symbol_index == '0)
        begin
            sym_sat = arc_pkg::SYM_W'(1);
        end
        else if (symbol_index > arc_pkg::SYM_W'(ALPHABET_SIZE))
        begin
            sym_sat = arc_pkg::SYM_W'(ALPHABET_SIZE);
        end
    end

    // Symbol counts are differences of neighbouring cumulative entries.
    always_comb
    begin
        for (int j = 0; j <= arc_pkg::NUM_COND; j++)
        begin
            p[j] = $signed({1'b0, table_reg[j]}) - $signed({1'b0, table_reg[j + 1]});
        end
    end

    // Each step of the search is tested at once; halving rounds toward zero.
    always_comb
    begin
        logic signed [arc_pkg::COUNT_W-1:0] half;
        half = '0;
        for (int j = 0; j < arc_pkg::NUM_COND; j++)
        begin
            half = (p[j] + $signed({{(arc_pkg::COUNT_W-1){1'b0}}, p[j][arc_pkg::COUNT_W-1]}))
                   >>> $clog2(arc_pkg::HALVE_BY);
            cond_next[j] = p[j + 1] > half;
        end
    end

    // k is the length of the leading run of passed tests, then floored.
    always_comb
    begin
        logic stop;
        stop   = 1'b0;
        k_next = '0;
        for (int j = 0; j < arc_pkg::NUM_COND; j++)
        begin
            if (!stop && cond_reg[j])
            begin
                k_next = k_next + arc_pkg::K_W'(1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
        if (k_next < arc_pkg::K_W'(arc_pkg::K_MIN))
        begin
            k_next = arc_pkg::K_W'(arc_pkg::K_MIN);
        end
    end

    always_comb
    begin
        logic [arc_pkg::S_W-1:0]    q;
        logic [arc_pkg::WORD_W-1:0] unary;
        logic [arc_pkg::WORD_W-1:0] rem_mask;
        q         = s_reg >> k_reg;
        unary     = ((arc_pkg::WORD_W'(1) << q) - arc_pkg::WORD_W'(1)) << (k_reg + 1'b1);
        rem_mask  = (arc_pkg::WORD_W'(1) << k_reg) - arc_pkg::WORD_W'(1);
        word_next = unary | (arc_pkg::WORD_W'(s_reg) & rem_mask);
        len_next  = arc_pkg::LEN_W'(q) + arc_pkg::LEN_W'(k_reg) + arc_pkg::LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_en)
        begin
            s_reg <= arc_pkg::S_W'(sym_sat - arc_pkg::SYM_W'(1));
        end
        if (cmd.cond_en)
        begin
            cond_reg <= cond_next;
        end
        if (cmd.k_en)
        begin
            k_reg <= k_next;
        end
        if (cmd.build_en)
        begin
            word_reg <= word_next;
            len_reg  <= len_next;
        end
    end

    assign code_word   = word_reg;
    assign code_length = len_reg;
    assign rice_k      = k_reg;

endmodule

/* verif/adaptive_rice_encoder_test.sv */
// ----------------------------------------------------------------------------
// adaptive_rice_encoder_test
// Self-checking testbench for the adaptive Rice encoder.
// ----------------------------------------------------------------------------
// Load beats fill the count table and encode beats are checked against a
// predictor that keeps its own copy of the table and derives k and the code
// word from it. The directed tests cover the empty table, the rank limits,
// ignored loads, the deepest k and the truncating halving of negative counts.
// Random count profiles with random ranks follow, then a long output hold
// and a stretch of traffic with no idling at all.
// ----------------------------------------------------------------------------
module adaptive_rice_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import arc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned RANDOM_BEATS = 650;
    localparam int unsigned STEADY_BEATS = 150;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic [K_W-1:0]    k;
    } rice_code_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    logic [EVAL_W-1:0] count_model [TABLE_DEPTH];
    rice_code_t        expected_codes [$];
    rice_code_t        want_code;
    rice_code_t        got_code;
    int unsigned       mismatch_count;
    int unsigned       cycle_count;
    int unsigned       effective_beats;
    int unsigned       hold_cycles;
    int unsigned       stall_cycles;
    bit                steady;
    bit                long_hold_req;

    adaptive_rice_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Signed count of symbol x, the difference of neighbouring cumulative entries.
    function automatic int symbol_count(input int x);
        return int'(count_model[x - 1]) - int'(count_model[x]);
    endfunction

    function automatic rice_code_t predict_code(input logic [SYM_W-1:0] rank);
        rice_code_t  code;
        int unsigned s;
        int unsigned q;
        int unsigned k;
        int          slot;
        logic [63:0] unary;
        if (rank == 0)
            s = 0;
        else if (rank > ALPHABET_SIZE_DEF)
            s = ALPHABET_SIZE_DEF - 1;
        else
            s = rank - 1;
        k = 0;
        slot = 1;
        while (k <= K_LIMIT &&
               symbol_count(slot + 1) > symbol_count(slot) / int'(HALVE_BY))
        begin
            slot++;
            k++;
        end
        if (k < K_MIN)
            k = K_MIN;
        q = s >> k;
        unary = (64'd1 << q) - 64'd1;
        code.word = WORD_W'((unary << (k + 1)) | 64'(s & ((32'd1 << k) - 1)));
        code.len  = LEN_W'(q + 1 + k);
        code.k    = K_W'(k);
        return code;
    endfunction

    // Offers one beat from a falling edge and returns at the falling edge after
    // it was taken, with tvalid still high so that back-to-back beats need no gap.
    task automatic send_beat(input logic fn, input logic [EIDX_W-1:0] idx,
                             input logic [EVAL_W-1:0] val,
                             input logic [SYM_W-1:0] rank);
        int unsigned gap;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, rank, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (fn == FUNC_ENCODE)
        begin
            expected_codes.push_back(predict_code(rank));
            effective_beats++;
        end
        else if (idx < TABLE_DEPTH)
        begin
            count_model[idx] = val;
            effective_beats++;
        end
        @(negedge clk);
    endtask

    task automatic load_entry(input logic [EIDX_W-1:0] idx, input logic [EVAL_W-1:0] val);
        send_beat(FUNC_LOAD, idx, val, SYM_W'($urandom));
    endtask

    task automatic encode_rank(input logic [SYM_W-1:0] rank);
        send_beat(FUNC_ENCODE, EIDX_W'($urandom), EVAL_W'($urandom), rank);
    endtask

    task automatic random_rank_encode();
        if ($urandom_range(0, 7) == 0)
            encode_rank(SYM_W'($urandom));
        else
            encode_rank(SYM_W'($urandom_range(1, ALPHABET_SIZE_DEF)));
    endtask

    // Builds a table from a run of counts that decay at a random rate, so that
    // the search for k stops at many different depths.
    task automatic load_profile();
        int          slope [1:TABLE_DEPTH-1];
        logic [15:0] cum [TABLE_DEPTH];
        int unsigned rate;
        rate = $urandom_range(5, 15);
        slope[1] = int'($urandom_range(0, 4000));
        if ($urandom_range(0, 4) == 0)
            slope[1] = -slope[1];
        for (int i = 2; i < TABLE_DEPTH; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                rate = $urandom_range(0, 8);
            slope[i] = slope[i - 1] * int'(rate) / 16 + int'($urandom_range(0, 6)) - 3;
        end
        cum[TABLE_DEPTH - 1] = 16'($urandom);
        for (int i = TABLE_DEPTH - 1; i >= 1; i--)
            cum[i - 1] = cum[i] + 16'(slope[i]);
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(EIDX_W'(i), cum[i]);
    endtask

    task automatic mixed_traffic(input int unsigned beats);
        int unsigned target;
        target = effective_beats + beats;
        while (effective_beats < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                load_profile();
                repeat ($urandom_range(1, 8)) random_rank_encode();
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                load_entry(EIDX_W'($urandom), EVAL_W'($urandom));
            end
            else
            begin
                random_rank_encode();
            end
        end
    endtask

    // With every count zero the search stops at once and k is clamped to its floor.
    task automatic test_empty_table();
        encode_rank(9'd1);
        encode_rank(9'd0);
        encode_rank(SYM_W'(ALPHABET_SIZE_DEF));
        encode_rank(9'd511);
    endtask

    // Equal counts keep the halving test true all the way to the deepest k.
    task automatic test_flat_profile();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(EIDX_W'(i), EVAL_W'(65535 - 100 * i));
        load_entry(4'd10, 16'd0);
        load_entry(4'd15, 16'hFFFF);
        encode_rank(SYM_W'(ALPHABET_SIZE_DEF));
    endtask

    // Negative counts where halving toward zero stops the search at k of three
    // but halving toward minus infinity would carry on.
    task automatic test_negative_halving();
        load_entry(4'd0, 16'd0);
        load_entry(4'd1, 16'd100);
        load_entry(4'd2, 16'd140);
        load_entry(4'd3, 16'd155);
        load_entry(4'd4, 16'd160);
        load_entry(4'd5, 16'd162);
        encode_rank(9'd2);
    endtask

    task automatic test_random_traffic();
        mixed_traffic(RANDOM_BEATS);
    endtask

    // The receiver stops for a long stretch while encodes keep being offered.
    task automatic test_output_hold();
        // The last beat must not stay on offer while waiting for the hold.
        s_tvalid <= 1'b0;
        long_hold_req = 1'b1;
        while (hold_cycles == 0)
            @(negedge clk);
        load_profile();
        repeat (10) random_rank_encode();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        mixed_traffic(STEADY_BEATS);
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = FUNC_LOAD;
        m_tready        = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        effective_beats = 0;
        hold_cycles     = 0;
        stall_cycles    = 0;
        steady          = 1'b0;
        long_hold_req   = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            count_model[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_flat_profile();
        test_negative_halving();
        test_random_traffic();
        test_output_hold();
        test_steady_stream();

        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Output side: random short stalls, and the long hold when one is asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cycles = LONG_HOLD;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_cycles > 0)
            begin
                stall_cycles--;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_cycles = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d: %s expected %0h got %0h", mismatch_count, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_code.word = m_tdata[40:0];
            got_code.len  = m_tdata[46:41];
            got_code.k    = m_tdata[50:47];
            if (expected_codes.size() == 0)
            begin
                report_mismatch("result beat with none outstanding", '0, 64'(m_tdata));
            end
            else
            begin
                want_code = expected_codes.pop_front();
                if (got_code.word != want_code.word)
                    report_mismatch("code_word", 64'(want_code.word), 64'(got_code.word));
                if (got_code.len != want_code.len)
                    report_mismatch("code_length", 64'(want_code.len), 64'(got_code.len));
                if (got_code.k != want_code.k)
                    report_mismatch("rice_k", 64'(want_code.k), 64'(got_code.k));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

endmodule
